// ----- hw/rtl/scpc_pkg.sv -----
package scpc_pkg;

  localparam int ANGLE_W    = 15;
  localparam int ERR_W      = 16;
  localparam int DUTY_W     = 16;
  localparam int VQ_W       = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_ADDR_W = 3;
  localparam int COS_W      = 15;   // Q14 magnitude, 0..16384

  // per-lane pipeline: angle/fold/index/correct/rom/mult/offset/scale, then restoring divide
  localparam int DIV_STEPS   = DUTY_W;
  localparam int LANE_STAGES = 8 + DIV_STEPS;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_ZERO_OFFSET    = 3'd0,
    REG_POLE_PAIRS     = 3'd1,
    REG_POSITION_GAIN  = 3'd2,
    REG_SUPPLY_VOLTAGE = 3'd3,
    REG_PWM_PERIOD     = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [15:0] supply;
    logic [15:0] period;
  } lane_cfg_t;

endpackage

// ----- hw/rtl/scpc_cos_rom.sv -----
module scpc_cos_rom #(
  parameter int TABLE_BITS = 10
) (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic [TABLE_BITS:0]               addr_i,
  output logic [scpc_pkg::COS_W-1:0]        data_o
);
  import scpc_pkg::*;

  localparam int TS = 1 << TABLE_BITS;

  typedef logic [COS_W-1:0] rom_t [TS];

  // shift-subtract quotient, only evaluated while building the table
  function automatic longint unsigned div_u64(longint unsigned n, longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // quarter-wave cosine, Q14, integer Taylor series through the x^16 term
  function automatic rom_t build_rom();
    rom_t              rom;
    longint unsigned   x;
    longint unsigned   x2;
    longint unsigned   term;
    longint            sm;
    for (int i = 0; i < TS; i++) begin
      x    = (longint'(i) * HALF_PI_Q30) >> TABLE_BITS;
      x2   = (x * x) >> 30;
      term = 64'd1 << 30;
      sm   = 64'sd1 << 30;
      for (int k = 1; k <= 8; k++) begin
        term = div_u64((term * x2) >> 30, 64'((2 * k - 1) * (2 * k)));
        if ((k & 1) == 1) sm = sm - longint'(term);
        else              sm = sm + longint'(term);
      end
      if (sm < 0) sm = 0;
      rom[i] = COS_W'((sm + 32768) >>> 16);
    end
    return rom;
  endfunction

  localparam rom_t ROM = build_rom();

  logic [COS_W-1:0] data_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= addr_i[TABLE_BITS] ? '0 : ROM[addr_i[TABLE_BITS-1:0]];
    end
  end

  assign data_o = data_q;

endmodule

// ----- hw/rtl/scpc_phase_lane.sv -----
module scpc_phase_lane #(
  parameter int TABLE_BITS      = 10,
  parameter int ANGLE_FRAC_BITS = 6,
  parameter int OFFSET          = 0
) (
  input  logic                                        clk_i,
  input  logic [scpc_pkg::LANE_STAGES-1:0]            adv_i,
  input  logic [$clog2(360 << ANGLE_FRAC_BITS)-1:0]   elec_i,
  input  logic signed [scpc_pkg::VQ_W-1:0]            vq_i,
  input  scpc_pkg::lane_cfg_t                         cfg_i,
  output logic [scpc_pkg::DUTY_W-1:0]                 duty_o
);
  import scpc_pkg::*;

  localparam int FULL = 360 << ANGLE_FRAC_BITS;
  localparam int QT   = 90 << ANGLE_FRAC_BITS;
  localparam int EL_W = $clog2(FULL);
  localparam int QTW  = $clog2(QT + 1);
  localparam int NW   = QTW + TABLE_BITS;
  localparam int M3   = ((2 ** NW) + QT - 1) / QT;
  localparam int M3W  = $clog2(M3 + 1);

  // L0: phase angle
  logic [EL_W:0]   psum;
  logic [EL_W-1:0] p_q;
  always_comb begin
    psum = {1'b0, elec_i} + (EL_W+1)'(OFFSET);
    if (psum >= (EL_W+1)'(FULL)) psum = psum - (EL_W+1)'(FULL);
  end
  always_ff @(posedge clk_i) begin
    if (adv_i[0]) p_q <= EL_W'(psum);
  end

  // L1: quadrant fold
  logic [QTW-1:0] rr_d, rr1_q, rr2_q;
  logic           neg_d, neg1_q, neg2_q, neg3_q, neg4_q;
  always_comb begin
    if (p_q < EL_W'(QT)) begin
      rr_d  = QTW'(p_q);
      neg_d = 1'b0;
    end else if (p_q < EL_W'(2 * QT)) begin
      rr_d  = QTW'(EL_W'(2 * QT) - p_q);
      neg_d = 1'b1;
    end else if (p_q < EL_W'(3 * QT)) begin
      rr_d  = QTW'(p_q - EL_W'(2 * QT));
      neg_d = 1'b1;
    end else begin
      rr_d  = QTW'(EL_W'(FULL) - p_q);
      neg_d = 1'b0;
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv_i[1]) begin
      rr1_q  <= rr_d;
      neg1_q <= neg_d;
    end
  end

  // L2: table index by reciprocal
  logic [NW+M3W-1:0] iprod_q;
  always_ff @(posedge clk_i) begin
    if (adv_i[2]) begin
      iprod_q <= (NW+M3W)'({rr1_q, {TABLE_BITS{1'b0}}}) * (NW+M3W)'(M3);
      rr2_q   <= rr1_q;
      neg2_q  <= neg1_q;
    end
  end

  // L3: correct overestimate by one
  logic [TABLE_BITS:0] idx_d, idx_q;
  always_comb begin
    idx_d = (TABLE_BITS+1)'(iprod_q >> NW);
    if ((NW+1)'(idx_d * QT) > (NW+1)'({rr2_q, {TABLE_BITS{1'b0}}}))
      idx_d = idx_d - 1'b1;
  end
  always_ff @(posedge clk_i) begin
    if (adv_i[3]) begin
      idx_q  <= idx_d;
      neg3_q <= neg2_q;
    end
  end

  // L4: table read
  logic [COS_W-1:0] cos_mag;
  scpc_cos_rom #(.TABLE_BITS(TABLE_BITS)) u_rom (
    .clk_i  (clk_i),
    .en_i   (adv_i[4]),
    .addr_i (idx_q),
    .data_o (cos_mag)
  );
  always_ff @(posedge clk_i) begin
    if (adv_i[4]) neg4_q <= neg3_q;
  end

  // L5: vq * cos
  logic signed [15:0] cos_s;
  logic signed [31:0] vprod_q;
  assign cos_s = neg4_q ? -$signed({1'b0, cos_mag}) : $signed({1'b0, cos_mag});
  always_ff @(posedge clk_i) begin
    if (adv_i[5]) vprod_q <= vq_i * cos_s;
  end

  // L6: offset by half supply, clamp at zero
  logic signed [32:0] nsum;
  logic [30:0]        num_q;
  assign nsum = $signed({vprod_q, 1'b0}) + $signed({3'b0, cfg_i.supply, 14'b0});
  always_ff @(posedge clk_i) begin
    if (adv_i[6]) num_q <= nsum[32] ? '0 : nsum[30:0];
  end

  // L7: scale by period, drop the 2^15 of the divisor
  logic [46:0] smul;
  logic [31:0] y_q;
  assign smul = 47'(num_q) * 47'(cfg_i.period);
  always_ff @(posedge clk_i) begin
    if (adv_i[7]) y_q <= smul[46:15];
  end

  // L8..: restoring divide by supply, one quotient bit per stage
  logic [31:0]       div_r_q [DIV_STEPS];
  logic [DUTY_W-1:0] div_q_q [DIV_STEPS];

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    localparam int B = DIV_STEPS - 1 - j;
    logic [31:0]       r_in;
    logic [DUTY_W-1:0] q_in;
    logic [32:0]       dv;
    logic              take;
    if (j == 0) begin : g_first
      assign r_in = y_q;
      assign q_in = '0;
    end else begin : g_next
      assign r_in = div_r_q[j-1];
      assign q_in = div_q_q[j-1];
    end
    assign dv   = 33'(cfg_i.supply) << B;
    assign take = {1'b0, r_in} >= dv;
    always_ff @(posedge clk_i) begin
      if (adv_i[8+j]) begin
        div_r_q[j] <= take ? 32'({1'b0, r_in} - dv) : r_in;
        div_q_q[j] <= {q_in[DUTY_W-2:0], take};
      end
    end
  end

  assign duty_o = (cfg_i.supply == '0) ? '0 : div_q_q[DIV_STEPS-1];

endmodule

// ----- hw/rtl/sine_commutation_position_p_control_core.sv -----
// Channel  | Dir | Fields (lsb first)                                      | Request when
// s_axis   | in  | mech_angle[14:0], position_error[30:15]                 | tvalid & tready
// m_axis   | out | duty_a, duty_b, duty_c, q_voltage[63:48], elec_angle    | tvalid & tready
// cfg      | in  | cfg_addr_i register index, cfg_wdata_i                  | cfg_we_i
//
// One request per cycle while the output is ready or any stage is empty.
// Stages: 5 for angle reduction and the proportional voltage, then per phase
// table index, cosine ROM read, multiply, scale and a 16-step restoring divide.
// Each stage holds its item until the next one is free, so bubbles are squeezed
// out and a stalled output blocks the input only when every stage is full.
// Reset clears valid bits and loads register defaults; no clearing pass.
module sine_commutation_position_p_control_core #(
  parameter int COS_TABLE_BITS  = 10,
  parameter int ANGLE_FRAC_BITS = 6
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [31:0]                           s_axis_tdata,  // mech_angle, position_error
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [79:0]                           m_axis_tdata,  // duty_a, duty_b, duty_c,
                                                               // q_voltage, elec_angle
  input  logic                                  cfg_we_i,
  input  logic [scpc_pkg::CFG_ADDR_W-1:0]       cfg_addr_i,
  input  logic [scpc_pkg::CFG_DATA_W-1:0]       cfg_wdata_i
);
  import scpc_pkg::*;

  localparam int FULL  = 360 << ANGLE_FRAC_BITS;
  localparam int HALF  = 180 << ANGLE_FRAC_BITS;
  localparam int QT    = 90 << ANGLE_FRAC_BITS;
  localparam int THIRD = 120 << ANGLE_FRAC_BITS;
  localparam int EL_W  = $clog2(FULL);
  localparam int FRONT = 5;
  localparam int NS    = FRONT + LANE_STAGES;
  localparam int UW    = 24;
  localparam int BIAS  = FULL * (((1 << 22) + FULL - 1) / FULL);
  localparam int M2    = ((1 << UW) + FULL - 1) / FULL;
  localparam int M2W   = $clog2(M2 + 1);
  localparam int VQ_AT = FRONT + 4;

  // config registers
  logic [14:0] zero_offset_q;
  logic [6:0]  pole_pairs_q;
  logic [15:0] position_gain_q;
  logic [15:0] supply_voltage_q;
  logic [15:0] pwm_period_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_offset_q    <= 15'd0;
      pole_pairs_q     <= 7'd11;
      position_gain_q  <= 16'd256;
      supply_voltage_q <= 16'd3072;
      pwm_period_q     <= 16'd4500;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        REG_ZERO_OFFSET:    zero_offset_q    <= cfg_wdata_i[14:0];
        REG_POLE_PAIRS:     pole_pairs_q     <= cfg_wdata_i[6:0];
        REG_POSITION_GAIN:  position_gain_q  <= cfg_wdata_i;
        REG_SUPPLY_VOLTAGE: supply_voltage_q <= cfg_wdata_i;
        REG_PWM_PERIOD:     pwm_period_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // pipeline flow: a stage moves when the output is ready or any stage at or after it is empty
  logic [NS-1:0] valid_q;
  logic [NS-1:0] adv;

  always_comb begin
    for (int k = 0; k < NS; k++) begin
      adv[k] = m_axis_tready || ((~valid_q >> k) != '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (adv[k]) valid_q[k] <= (k == 0) ? s_axis_tvalid : valid_q[(k == 0) ? 0 : k-1];
      end
    end
  end

  assign s_axis_tready = adv[0];
  assign m_axis_tvalid = valid_q[NS-1];

  // S0: offset angle, wrap error
  logic [ANGLE_W-1:0]       mech_in;
  logic signed [ERR_W-1:0]  err_in;
  logic signed [17:0]       err_w;
  logic signed [15:0]       diff_q;
  logic signed [17:0]       err_q;

  assign mech_in = s_axis_tdata[14:0];
  assign err_in  = s_axis_tdata[30:15];

  always_comb begin
    err_w = 18'(err_in);
    if (err_w > 18'sd0 + 18'(HALF))        err_w = err_w - 18'(FULL);
    else if (err_w < -(18'sd0 + 18'(HALF))) err_w = err_w + 18'(FULL);
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      diff_q <= $signed({1'b0, mech_in}) - $signed({1'b0, zero_offset_q});
      err_q  <= err_w;
    end
  end

  // S1: scale by pole pairs, gain product
  logic signed [22:0] raw_q;
  logic signed [34:0] gp_q;
  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      raw_q <= 23'(diff_q * $signed({1'b0, pole_pairs_q})) + 23'(QT);
      gp_q  <= $signed({1'b0, position_gain_q}) * err_q;
    end
  end

  // S2: bias angle positive; voltage truncated toward zero and clamped
  logic [UW-1:0]           u_q, u3_q;
  logic signed [34:0]      vt;
  logic signed [34:0]      half_s;
  logic signed [VQ_W-1:0]  vq_d;
  logic signed [VQ_W-1:0]  vq_q [FRONT:NS-1];

  always_comb begin
    half_s = $signed({20'b0, supply_voltage_q[15:1]});
    vt     = (gp_q + (gp_q[34] ? 35'((1 << ANGLE_FRAC_BITS) - 1) : 35'sd0))
             >>> ANGLE_FRAC_BITS;
    if (vt > half_s)        vq_d = VQ_W'(half_s);
    else if (vt < -half_s)  vq_d = VQ_W'(-half_s);
    else                    vq_d = VQ_W'(vt);
  end

  logic signed [VQ_W-1:0] vq2_q, vq3_q, vq4_q;

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      u_q   <= UW'($signed(UW'(raw_q)) + $signed(UW'(BIAS)));
      vq2_q <= vq_d;
    end
  end

  // S3: quotient estimate for mod full turn
  logic [UW+M2W-1:0] qprod_q;
  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      qprod_q <= (UW+M2W)'(u_q) * (UW+M2W)'(M2);
      u3_q    <= u_q;
      vq3_q   <= vq2_q;
    end
  end

  // S4: remainder, estimate is high by at most one
  logic [M2W-1:0]       qest;
  logic signed [UW+1:0] rem;
  logic [EL_W-1:0]      elec4_q;
  logic [EL_W-1:0]      elec_q [FRONT:NS-1];

  always_comb begin
    qest = M2W'(qprod_q >> UW);
    rem  = $signed({2'b0, u3_q}) - $signed((UW+2)'(qest * FULL));
    if (rem < 0) rem = rem + (UW+2)'(FULL);
  end

  always_ff @(posedge clk_i) begin
    if (adv[4]) begin
      elec4_q <= EL_W'(rem);
      vq4_q   <= vq3_q;
    end
  end

  // side channels travel along the lanes
  always_ff @(posedge clk_i) begin
    if (adv[FRONT]) begin
      vq_q[FRONT]   <= vq4_q;
      elec_q[FRONT] <= elec4_q;
    end
    for (int k = FRONT + 1; k < NS; k++) begin
      if (adv[k]) begin
        elec_q[k] <= elec_q[k-1];
        vq_q[k]   <= vq_q[k-1];
      end
    end
  end

  lane_cfg_t lane_cfg;
  assign lane_cfg = '{supply: supply_voltage_q, period: pwm_period_q};

  logic [DUTY_W-1:0] duty_a, duty_b, duty_c;

  scpc_phase_lane #(
    .TABLE_BITS(COS_TABLE_BITS), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .OFFSET(0)
  ) u_lane_a (
    .clk_i(clk_i), .adv_i(adv[NS-1:FRONT]), .elec_i(elec4_q),
    .vq_i(vq_q[VQ_AT]), .cfg_i(lane_cfg), .duty_o(duty_a)
  );

  scpc_phase_lane #(
    .TABLE_BITS(COS_TABLE_BITS), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .OFFSET(2 * THIRD)
  ) u_lane_b (
    .clk_i(clk_i), .adv_i(adv[NS-1:FRONT]), .elec_i(elec4_q),
    .vq_i(vq_q[VQ_AT]), .cfg_i(lane_cfg), .duty_o(duty_b)
  );

  scpc_phase_lane #(
    .TABLE_BITS(COS_TABLE_BITS), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .OFFSET(THIRD)
  ) u_lane_c (
    .clk_i(clk_i), .adv_i(adv[NS-1:FRONT]), .elec_i(elec4_q),
    .vq_i(vq_q[VQ_AT]), .cfg_i(lane_cfg), .duty_o(duty_c)
  );

  assign m_axis_tdata = {1'b0, ANGLE_W'(elec_q[NS-1]), vq_q[NS-1], duty_c, duty_b, duty_a};

  ap_elec_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (elec_q[NS-1] < EL_W'(FULL)))
    else $error("electrical angle not reduced");

  ap_vq_sym: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (vq_q[NS-1] != {1'b1, {(VQ_W-1){1'b0}}}))
    else $error("voltage clamp out of symmetric range");

  ap_bubble_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_q[0] |-> s_axis_tready)
    else $error("input stalled with empty first stage");

  ap_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (&valid_q && !m_axis_tready) |-> !s_axis_tready)
    else $error("request taken into a full pipeline");

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
  import scpc_pkg::*;

  localparam int FULL_TURN    = 23040;
  localparam int QUARTER_TURN = 5760;
  localparam int HALF_TURN    = 11520;
  localparam int THIRD_TURN   = 7680;
  localparam int ROM_SIZE     = 1024;
  localparam int FRAC_DIV     = 64;
  localparam int TIMEOUT_CYC  = 600000;
  localparam int LATENCY_CYC  = 29;
  localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 3'd5;

  typedef struct {
    logic [15:0]        duty_a;
    logic [15:0]        duty_b;
    logic [15:0]        duty_c;
    logic signed [15:0] q_voltage;
    logic [14:0]        elec_angle;
  } drive_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // mech_angle[14:0], position_error[30:15]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;        // duty_a, duty_b, duty_c, q_voltage, elec_angle
  logic        cfg_we_i = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  sine_commutation_position_p_control_core DUT (.*);

  // shadow registers
  longint zero_offset_q = 0, pole_pairs_q = 11, gain_q = 256;
  longint supply_q = 3072, period_q = 4500;

  int     cos_rom[ROM_SIZE];
  drive_t drive_q[$];
  int     n_errors = 0;
  bit     quiet = 1'b0;
  int     hold_seq = 0;
  longint cycles = 0;

  initial forever #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > TIMEOUT_CYC) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  function automatic void build_cos_rom();
    longint unsigned x, x2, term;
    longint sum;
    for (int i = 0; i < ROM_SIZE; i++) begin
      x = (longint'(i) * HALF_PI_Q30) >> 10;
      x2 = (x * x) >> 30;
      term = 64'd1 << 30;
      sum = longint'(term);
      for (int k = 1; k <= 8; k++) begin
        term = ((term * x2) >> 30) / longint'((2 * k - 1) * (2 * k));
        if (k % 2 == 1) sum -= longint'(term);
        else sum += longint'(term);
      end
      if (sum < 0) sum = 0;
      cos_rom[i] = int'((sum + 32768) >>> 16);
    end
  endfunction

  function automatic longint quarter_cos(longint r);
    longint idx = (r * ROM_SIZE) / QUARTER_TURN;
    if (idx < 0 || idx >= ROM_SIZE) return 0;
    return cos_rom[idx];
  endfunction

  function automatic longint phase_cos(longint p);
    longint q, r;
    p = p % FULL_TURN;
    if (p < 0) p += FULL_TURN;
    q = p / QUARTER_TURN;
    r = p % QUARTER_TURN;
    case (q)
      0: return quarter_cos(r);
      1: return -quarter_cos(QUARTER_TURN - r);
      2: return -quarter_cos(r);
      default: return quarter_cos(QUARTER_TURN - r);
    endcase
  endfunction

  function automatic logic [15:0] pwm_compare(longint vq, longint c);
    longint num = 2 * vq * c + supply_q * 16384;
    if (supply_q == 0 || num < 0) return '0;
    return 16'((num * period_q) / (supply_q * 32768));
  endfunction

  function automatic drive_t commutate(logic [14:0] mech, logic signed [15:0] err_in);
    drive_t d;
    longint elec, err, vq, half;
    err = err_in;
    elec = (longint'(mech) - zero_offset_q) * pole_pairs_q + QUARTER_TURN;
    elec = elec % FULL_TURN;
    if (elec < 0) elec += FULL_TURN;
    if (err > HALF_TURN) err -= FULL_TURN;
    else if (err < -HALF_TURN) err += FULL_TURN;
    vq = (gain_q * err) / FRAC_DIV;
    half = supply_q >> 1;
    if (vq > half) vq = half;
    if (vq < -half) vq = -half;
    d.duty_a = pwm_compare(vq, phase_cos(elec));
    d.duty_b = pwm_compare(vq, phase_cos(elec + 2 * THIRD_TURN));
    d.duty_c = pwm_compare(vq, phase_cos(elec + THIRD_TURN));
    d.q_voltage = 16'(vq);
    d.elec_angle = 15'(elec);
    return d;
  endfunction

  // request side; called just after a rising edge
  task automatic send_sample(logic [14:0] mech, logic [15:0] err);
    int gap;
    bit ok;
    gap = 0;
    if (!quiet) begin
      case ($urandom_range(0, 19))
        0: gap = $urandom_range(10, 30);
        1, 2, 3, 4, 5, 6: gap = $urandom_range(1, 3);
        default: gap = 0;
      endcase
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {1'b0, err, mech};
    do begin
      @(negedge clk_i);
      ok = s_axis_tready;
      @(posedge clk_i);
    end while (!ok);
    drive_q.push_back(commutate(mech, err));
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (drive_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY_CYC + 4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [15:0] val);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_ZERO_OFFSET:    zero_offset_q = val[14:0];
      REG_POLE_PAIRS:     pole_pairs_q = val[6:0];
      REG_POSITION_GAIN:  gain_q = val;
      REG_SUPPLY_VOLTAGE: supply_q = val;
      REG_PWM_PERIOD:     period_q = val;
      default: ;
    endcase
  endtask

  task automatic set_config(int zo, int pp, int g, int sv, int per);
    drain();
    write_reg(REG_ZERO_OFFSET, 16'(zo));
    write_reg(REG_POLE_PAIRS, 16'(pp));
    write_reg(REG_POSITION_GAIN, 16'(g));
    write_reg(REG_SUPPLY_VOLTAGE, 16'(sv));
    write_reg(REG_PWM_PERIOD, 16'(per));
  endtask

  task automatic send_random(int n);
    logic [14:0] mech;
    logic [15:0] err;
    for (int i = 0; i < n; i++) begin
      mech = ($urandom_range(0, 9) == 0) ? 15'($urandom) : 15'($urandom_range(0, 23039));
      if ($urandom_range(0, 9) == 0) err = 16'($urandom);
      else err = 16'($urandom_range(0, 46080) - 23040);
      send_sample(mech, err);
    end
  endtask

  task automatic test_defaults_directed();
    int mechs[5] = '{0, 23039, 32767, 5760, 11520};
    int errs[15] = '{0, 11520, -11520, 11521, -11521, 23040, -23040, 32767, -32768,
                     1, -1, 64, -64, 3000, -3000};
    for (int i = 0; i < 15; i++) send_sample(15'(mechs[i % 5]), 16'(errs[i]));
    for (int i = 0; i < 5; i++) send_sample(15'(mechs[i]), 16'($urandom));
  endtask

  task automatic test_special_cases();
    // zero supply: duties and voltage zero
    set_config(0, 11, 256, 0, 4500);
    send_sample(15'd100, 16'd500);
    send_sample(15'd23039, -16'sd500);
    // zero pole pairs: angle pinned to a quarter turn
    set_config(23039, 0, 65535, 65535, 65535);
    send_sample(15'd0, 16'd32767);
    send_sample(15'd32767, -16'sd32768);
    // an index past the register list is dropped
    drain();
    write_reg(REG_UNUSED, 16'hFFFF);
    send_sample(15'd1234, 16'd77);
  endtask

  task automatic test_register_sweep();
    set_config(23039, 64, 0, 256, 1);
    send_random(60);
    set_config(0, 1, 65535, 65535, 65535);
    send_random(60);
    set_config(12345, 127, 40000, 256, 65535);
    send_random(60);
  endtask

  task automatic test_random_configs();
    for (int ph = 0; ph < 6; ph++) begin
      set_config($urandom_range(0, 23039), $urandom_range(1, 64), $urandom_range(0, 65535),
                 $urandom_range(256, 65535), $urandom_range(1, 65535));
      quiet = (ph % 3 == 2);
      send_random(180);
      quiet = 1'b0;
    end
  endtask

  task automatic test_backpressure();
    quiet = 1'b1;
    hold_seq++;
    send_random(120);
    quiet = 1'b0;
  endtask

  // result side: random stalls plus one long hold-off at the start of the backpressure test
  int stall_left = 0;
  int hold_seen = 0;
  always @(posedge clk_i) begin
    if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      stall_left <= 300;
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(0, 2);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // request seen at the falling edge completes at the next rising edge
  always @(negedge clk_i) begin
    drive_t exp_d;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (drive_q.size() == 0) begin
        $error("result with nothing expected: %h", m_axis_tdata);
        n_errors++;
      end else begin
        exp_d = drive_q.pop_front();
        if (m_axis_tdata[15:0] !== exp_d.duty_a) begin
          $error("duty_a exp %0d got %0d", exp_d.duty_a, m_axis_tdata[15:0]);
          n_errors++;
        end
        if (m_axis_tdata[31:16] !== exp_d.duty_b) begin
          $error("duty_b exp %0d got %0d", exp_d.duty_b, m_axis_tdata[31:16]);
          n_errors++;
        end
        if (m_axis_tdata[47:32] !== exp_d.duty_c) begin
          $error("duty_c exp %0d got %0d", exp_d.duty_c, m_axis_tdata[47:32]);
          n_errors++;
        end
        if (m_axis_tdata[63:48] !== exp_d.q_voltage) begin
          $error("q_voltage exp %0d got %0d", exp_d.q_voltage,
                 $signed(m_axis_tdata[63:48]));
          n_errors++;
        end
        if (m_axis_tdata[78:64] !== exp_d.elec_angle) begin
          $error("elec_angle exp %0d got %0d", exp_d.elec_angle, m_axis_tdata[78:64]);
          n_errors++;
        end
      end
    end
  end

  initial begin
    build_cos_rom();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_defaults_directed();
    test_special_cases();
    test_register_sweep();
    test_random_configs();
    test_backpressure();
    drain();
    if (n_errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
